// ===== hdl/cte_pkg.sv =====
// capability table engine: shared constants, codes and table write structs
// no dependencies; used by the interfaces, the table store and the top level
`default_nettype none

package cte_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // request and response field widths
    localparam int MODE_W   = 2;
    localparam int PID_W    = 32;
    localparam int EIDX_W   = 16;
    localparam int RIGHTS_W = 8;
    localparam int STATUS_W = 3;
    localparam int NEWIDX_W = 9;

    // rights bits
    localparam logic [RIGHTS_W-1:0] RIGHTS_ALL     = 8'hFF;
    localparam logic [RIGHTS_W-1:0] RIGHT_DELEGATE = 8'h40;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_MINT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VERIFY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REVOKE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OWNER   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NODELEG = 3'd4;

    // new entry written by a successful mint
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [PID_W-1:0]    owner;
        logic [RIGHTS_W-1:0] rights;
        logic [IDX_W-1:0]    parent;
    } t_mint_wr;

    // revoked mark and subtree flag written during a revoke
    typedef struct packed {
        logic             rev_en;
        logic             sub_en;
        logic [IDX_W-1:0] addr;
        logic             sub_val;
    } t_mark_wr;

endpackage

`default_nettype wire

// ===== hdl/cte_req_if.sv =====
// request and response channels of the capability table engine
// depends on cte_pkg for field widths
`default_nettype none

interface cte_req_if;
    logic                          valid;
    logic                          ready;
    logic [cte_pkg::MODE_W-1:0]    mode;
    logic [cte_pkg::PID_W-1:0]     caller_pid;
    logic [cte_pkg::EIDX_W-1:0]    entry_index;
    logic [cte_pkg::PID_W-1:0]     grantee_pid;
    logic [cte_pkg::RIGHTS_W-1:0]  rights_mask;

    modport source (output valid, mode, caller_pid, entry_index, grantee_pid, rights_mask,
                    input ready);
    modport sink   (input valid, mode, caller_pid, entry_index, grantee_pid, rights_mask,
                    output ready);
endinterface

interface cte_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cte_pkg::STATUS_W-1:0]  status;
    logic [cte_pkg::NEWIDX_W-1:0]  new_index;
    logic                          granted;

    modport source (output valid, status, new_index, granted, input ready);
    modport sink   (input valid, status, new_index, granted, output ready);
endinterface

`default_nettype wire

// ===== hdl/cte_tables.sv =====
// capability table storage: owner, rights, parent, revoked and subtree memories
// depends on cte_pkg; every read is registered, one write port per memory
`default_nettype none

module cte_tables (
    input  logic                          i_clk,
    input  logic [cte_pkg::IDX_W-1:0]     i_rd_addr,
    input  logic [cte_pkg::IDX_W-1:0]     i_walk_addr,
    input  logic [cte_pkg::IDX_W-1:0]     i_sub_addr,
    input  cte_pkg::t_mint_wr             i_mint,
    input  cte_pkg::t_mark_wr             i_mark,
    output logic [cte_pkg::PID_W-1:0]     o_owner,
    output logic [cte_pkg::RIGHTS_W-1:0]  o_rights,
    output logic                          o_revoked,
    output logic [cte_pkg::IDX_W-1:0]     o_parent,
    output logic                          o_sub
);

    logic [cte_pkg::PID_W-1:0]    owner_mem  [cte_pkg::TABLE_DEPTH];
    logic [cte_pkg::RIGHTS_W-1:0] rights_mem [cte_pkg::TABLE_DEPTH];
    logic [cte_pkg::IDX_W-1:0]    parent_mem [cte_pkg::TABLE_DEPTH];
    logic                         rev_mem    [cte_pkg::TABLE_DEPTH];
    logic                         sub_mem    [cte_pkg::TABLE_DEPTH];

    logic [cte_pkg::PID_W-1:0]    r_owner;
    logic [cte_pkg::RIGHTS_W-1:0] r_rights;
    logic                         r_revoked;
    logic [cte_pkg::IDX_W-1:0]    r_parent;
    logic                         r_sub;

    // new entry from mint
    always_ff @(posedge i_clk) begin
        if (i_mint.en) begin
            owner_mem[i_mint.addr]  <= i_mint.owner;
            rights_mem[i_mint.addr] <= i_mint.rights;
            parent_mem[i_mint.addr] <= i_mint.parent;
        end
    end

    // revoked mark: cleared by mint, set by revoke
    always_ff @(posedge i_clk) begin
        if (i_mint.en) begin
            rev_mem[i_mint.addr] <= 1'b0;
        end else if (i_mark.rev_en) begin
            rev_mem[i_mark.addr] <= 1'b1;
        end
    end

    // subtree membership of the current revoke pass
    always_ff @(posedge i_clk) begin
        if (i_mark.sub_en) begin
            sub_mem[i_mark.addr] <= i_mark.sub_val;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_owner   <= owner_mem[i_rd_addr];
        r_rights  <= rights_mem[i_rd_addr];
        r_revoked <= rev_mem[i_rd_addr];
        r_parent  <= parent_mem[i_walk_addr];
        r_sub     <= sub_mem[i_sub_addr];
    end

    assign o_owner   = r_owner;
    assign o_rights  = r_rights;
    assign o_revoked = r_revoked;
    assign o_parent  = r_parent;
    assign o_sub     = r_sub;

endmodule

`default_nettype wire

// ===== hdl/capability_table_engine_unit.sv =====
// Capability table engine. Takes one request at a time (ready only while idle) and returns
// one response per request through an output register, so a new request can be taken while
// the previous response still waits. Mint, verify, a revoke of an out-of-range index or of
// the last live entry and the unused mode read the table at the requested index as the
// request is taken (registered read), then check and write in the check state. Revoke of
// entry k walks every live entry above k in order; each step is a chained parent read then
// a subtree-flag read on the table memories before the mark is written. A result that meets
// a busy output register is parked. No clearing pass after reset; entry 0 is held apart.
// depends on cte_pkg, cte_req_if/cte_rsp_if and cte_tables
`default_nettype none

module capability_table_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cte_req_if.sink    i_req,
    cte_rsp_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WPAR,
        S_WSUB,
        S_WWR,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic [cte_pkg::MODE_W-1:0]   r_mode;
    logic [cte_pkg::PID_W-1:0]    r_pid;
    logic [cte_pkg::EIDX_W-1:0]   r_idx;
    logic [cte_pkg::PID_W-1:0]    r_target;
    logic [cte_pkg::RIGHTS_W-1:0] r_rights;

    // table control state
    logic [cte_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_rev0, n_rev0;
    logic [cte_pkg::CNT_W-1:0] r_walk_i, n_walk_i;
    logic                      r_inr, n_inr;

    // pending and output results
    logic [cte_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [cte_pkg::NEWIDX_W-1:0] r_res_new, n_res_new;
    logic                         r_res_granted, n_res_granted;
    logic                         r_out_valid, n_out_valid;
    logic [cte_pkg::STATUS_W-1:0] r_status, n_status;
    logic [cte_pkg::NEWIDX_W-1:0] r_new_index, n_new_index;
    logic                         r_granted, n_granted;

    // table ports
    cte_pkg::t_mint_wr            mint_wr;
    cte_pkg::t_mark_wr            mark_wr;
    logic [cte_pkg::PID_W-1:0]    tbl_owner;
    logic [cte_pkg::RIGHTS_W-1:0] tbl_rights;
    logic                         tbl_rev;
    logic [cte_pkg::IDX_W-1:0]    tbl_parent;
    logic                         tbl_sub;

    logic                         accept;
    logic                         slot_free;
    logic                         is_zero;
    logic                         idx_ok;
    logic                         full;
    logic [cte_pkg::PID_W-1:0]    ent_owner;
    logic [cte_pkg::RIGHTS_W-1:0] ent_rights;
    logic                         ent_rev;
    logic                         fin;
    logic [cte_pkg::STATUS_W-1:0] fin_status;
    logic [cte_pkg::NEWIDX_W-1:0] fin_new;
    logic                         fin_granted;
    logic                         sub_hit;
    logic [cte_pkg::CNT_W-1:0]    walk_next;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.new_index = r_new_index;
    assign o_rsp.granted   = r_granted;

    // table store
    cte_tables u_tables (
        .i_clk       (i_clk),
        .i_rd_addr   (i_req.entry_index[cte_pkg::IDX_W-1:0]),
        .i_walk_addr (r_walk_i[cte_pkg::IDX_W-1:0]),
        .i_sub_addr  (tbl_parent),
        .i_mint      (mint_wr),
        .i_mark      (mark_wr),
        .o_owner     (tbl_owner),
        .o_rights    (tbl_rights),
        .o_revoked   (tbl_rev),
        .o_parent    (tbl_parent),
        .o_sub       (tbl_sub)
    );

    // entry 0 is the root and lives outside the memories
    assign is_zero    = (r_idx == '0);
    assign idx_ok     = ({16'b0, r_idx} < 32'(r_count));
    assign full       = (r_count >= cte_pkg::CNT_W'(cte_pkg::TABLE_DEPTH));
    assign ent_owner  = is_zero ? '0 : tbl_owner;
    assign ent_rights = is_zero ? cte_pkg::RIGHTS_ALL : tbl_rights;
    assign ent_rev    = is_zero ? r_rev0 : tbl_rev;
    assign sub_hit    = r_inr && tbl_sub;
    assign walk_next  = r_walk_i + cte_pkg::CNT_W'(1);

    // sequencer next state
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rev0        = r_rev0;
        n_walk_i      = r_walk_i;
        n_inr         = r_inr;
        n_res_status  = r_res_status;
        n_res_new     = r_res_new;
        n_res_granted = r_res_granted;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_status      = r_status;
        n_new_index   = r_new_index;
        n_granted     = r_granted;
        fin           = 1'b0;
        fin_status    = cte_pkg::ST_OK;
        fin_new       = '0;
        fin_granted   = 1'b0;
        mint_wr       = '0;
        mark_wr       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_mode)
                    cte_pkg::MODE_MINT: begin
                        fin = 1'b1;
                        if (full) begin
                            fin_status = cte_pkg::ST_FULL;
                        end else if (!idx_ok) begin
                            fin_status = cte_pkg::ST_RANGE;
                        end else if (ent_rev || (ent_owner != r_pid)) begin
                            fin_status = cte_pkg::ST_OWNER;
                        end else if ((ent_rights & cte_pkg::RIGHT_DELEGATE) == '0) begin
                            fin_status = cte_pkg::ST_NODELEG;
                        end else begin
                            mint_wr.en     = 1'b1;
                            mint_wr.addr   = r_count[cte_pkg::IDX_W-1:0];
                            mint_wr.owner  = r_target;
                            mint_wr.rights = r_rights & ent_rights;
                            mint_wr.parent = r_idx[cte_pkg::IDX_W-1:0];
                            fin_new        = cte_pkg::NEWIDX_W'(r_count);
                            n_count        = r_count + cte_pkg::CNT_W'(1);
                        end
                    end
                    cte_pkg::MODE_VERIFY: begin
                        fin         = 1'b1;
                        fin_granted = idx_ok && !ent_rev && (ent_owner == r_pid)
                                      && ((ent_rights & r_rights) == r_rights);
                    end
                    cte_pkg::MODE_REVOKE: begin
                        if (!idx_ok) begin
                            fin        = 1'b1;
                            fin_status = cte_pkg::ST_RANGE;
                        end else begin
                            // mark the head of the subtree, then walk the entries above it
                            mark_wr.sub_en  = 1'b1;
                            mark_wr.sub_val = 1'b1;
                            mark_wr.addr    = r_idx[cte_pkg::IDX_W-1:0];
                            mark_wr.rev_en  = !is_zero;
                            if (is_zero) begin
                                n_rev0 = 1'b1;
                            end
                            n_walk_i = cte_pkg::CNT_W'(r_idx) + cte_pkg::CNT_W'(1);
                            if ((cte_pkg::CNT_W'(r_idx) + cte_pkg::CNT_W'(1)) < r_count) begin
                                n_state = S_WPAR;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_WPAR: begin
                n_state = S_WSUB;
            end
            S_WSUB: begin
                // parent lies inside the walked range
                n_inr   = (tbl_parent >= r_idx[cte_pkg::IDX_W-1:0])
                          && (cte_pkg::CNT_W'(tbl_parent) < r_walk_i);
                n_state = S_WWR;
            end
            S_WWR: begin
                mark_wr.sub_en  = 1'b1;
                mark_wr.sub_val = sub_hit;
                mark_wr.rev_en  = sub_hit;
                mark_wr.addr    = r_walk_i[cte_pkg::IDX_W-1:0];
                n_walk_i        = walk_next;
                if (walk_next < r_count) begin
                    n_state = S_WPAR;
                end else begin
                    fin = 1'b1;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_new_index = r_res_new;
                    n_granted   = r_res_granted;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result to the output register, or park it while the slot is busy
        if (fin) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_status    = fin_status;
                n_new_index = fin_new;
                n_granted   = fin_granted;
                n_state     = S_IDLE;
            end else begin
                n_res_status  = fin_status;
                n_res_new     = fin_new;
                n_res_granted = fin_granted;
                n_state       = S_DONE;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= cte_pkg::CNT_W'(1);
            r_rev0      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rev0      <= n_rev0;
            r_out_valid <= n_out_valid;
        end
        r_walk_i      <= n_walk_i;
        r_inr         <= n_inr;
        r_res_status  <= n_res_status;
        r_res_new     <= n_res_new;
        r_res_granted <= n_res_granted;
        r_status      <= n_status;
        r_new_index   <= n_new_index;
        r_granted     <= n_granted;
        if (accept) begin
            r_mode   <= i_req.mode;
            r_pid    <= i_req.caller_pid;
            r_idx    <= i_req.entry_index;
            r_target <= i_req.grantee_pid;
            r_rights <= i_req.rights_mask;
        end
    end

`ifndef ASSERT_OFF
    // live entry count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= cte_pkg::CNT_W'(1))
        && (r_count <= cte_pkg::CNT_W'(cte_pkg::TABLE_DEPTH)))
        else $error("entry count out of range");

    // a taken request always goes to the check cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("request not followed by check cycle");

    // the count only grows by one, and only on a mint
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
        |-> (($past(r_state) == S_EXEC) && ($past(r_mode) == cte_pkg::MODE_MINT)
             && (r_count == ($past(r_count) + cte_pkg::CNT_W'(1)))))
        else $error("entry count changed outside mint");

    // revoke walk never steps past the live entries
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WPAR) || (r_state == S_WSUB) || (r_state == S_WWR))
        |-> (r_walk_i < r_count))
        else $error("revoke walk beyond live entries");
`endif

endmodule

`default_nettype wire
